[hw/rtl/cmt_pkg.sv]
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types and constants of the command code mapping table: the control
// and status bundles between controller and datapath, and the beat layouts.
// ----------------------------------------------------------------------------
package cmt_pkg;

   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned WR_CMD_W   = 8;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [WR_CMD_W-1:0] WRITE_CMD_BASE = 8'h80;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request beat
      logic search;    // compare the request against every entry
      logic commit;    // resolve the first match, update table, load result
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // result register empty or being taken this cycle
   } dp_status_type;

endpackage

[hw/rtl/command_code_mapping_table.sv]
// ----------------------------------------------------------------------------
// command_code_mapping_table
// Maps a device register access to a table slot (command code). A read hits
// the lowest entry with the same address and byte count, a write the lowest
// entry with the same address and its write flag set. A miss takes the
// round-robin slot, requests a device table write at 0x80 plus the slot, and
// clears that slot if the write reported failure. Each request runs in two
// steps: a search step compares against all entries at once and registers
// the matches, and a commit step resolves the first match, updates the
// table and loads the result register once it can take a beat. A new request
// can enter while its predecessor commits. The table is cleared by reset.
// ----------------------------------------------------------------------------
module command_code_mapping_table #(
   parameter int unsigned TABLE_ENTRIES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // register_address[15:0] byte_count[23:16] write_ok[24], rest zero
   input  logic [cmt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // is_read[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // command_code[2:0] hit[3] table_write_request[4]
   // table_write_command[12:5] failed[13], rest zero
   output logic [cmt_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import cmt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   cmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cmt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hw/rtl/cmt_ctrl.sv]
// ----------------------------------------------------------------------------
// cmt_ctrl
// Sequencer of the mapping table: accepts a request beat, runs the search
// cycle, then the commit cycle once the result register can take a beat.
// ----------------------------------------------------------------------------
module cmt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  cmt_pkg::dp_status_type status,
   output cmt_pkg::ctrl_cmd_type  cmd
);
   import cmt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      commit_now;

   assign commit_now  = (state_ff == ST_COMMIT) && status.out_free;
   // a new beat can enter in the same cycle the previous one commits
   assign req_tready  = (state_ff == ST_IDLE) || commit_now;
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.search  = (state_ff == ST_SEARCH);
   assign cmd.commit  = commit_now;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) state_in = req_tvalid ? ST_SEARCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/cmt_dp.sv]
// ----------------------------------------------------------------------------
// cmt_dp
// Datapath of the mapping table: request latch, entry registers with their
// parallel match, first-match encoder, round-robin pointer, result register.
// ----------------------------------------------------------------------------
module cmt_dp #(
   parameter int unsigned TABLE_ENTRIES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cmt_pkg::ctrl_cmd_type              cmd,
   output cmt_pkg::dp_status_type             status,
   input  logic [cmt_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cmt_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import cmt_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

   // request latch
   logic [ADDR_W-1:0]  req_addr_ff;
   logic [COUNT_W-1:0] req_count_ff;
   logic               req_read_ff;
   logic               req_ok_ff;

   // table entries
   logic [ADDR_W-1:0]  entry_addr_ff  [TABLE_ENTRIES];
   logic [COUNT_W-1:0] entry_count_ff [TABLE_ENTRIES];
   logic               entry_wflag_ff [TABLE_ENTRIES];
   logic [IDX_W-1:0]   next_slot_ff;
   logic [IDX_W-1:0]   next_slot_in;

   logic [TABLE_ENTRIES-1:0] match_in;
   logic [TABLE_ENTRIES-1:0] match_ff;
   logic                     found;
   logic [IDX_W-1:0]         first_idx;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [CODE_W-1:0]     res_code;
   logic [WR_CMD_W-1:0]   res_wr_cmd;

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_addr_ff  <= req_tdata[ADDR_W-1:0];
         req_count_ff <= req_tdata[ADDR_W+COUNT_W-1:ADDR_W];
         req_ok_ff    <= req_tdata[ADDR_W+COUNT_W];
         req_read_ff  <= req_tuser;
      end
   end

   // one comparator per entry
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_in[i] = (entry_addr_ff[i] == req_addr_ff) &&
                       (req_read_ff ? (entry_count_ff[i] == req_count_ff)
                                    : entry_wflag_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) match_ff <= match_in;
   end

   // lowest matching index wins
   always_comb begin
      found     = 1'b0;
      first_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            found     = 1'b1;
            first_idx = IDX_W'(i);
         end
      end
   end

   assign next_slot_in = (next_slot_ff == IDX_W'(TABLE_ENTRIES - 1)) ? '0
                                                                   : next_slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_addr_ff[i]  <= '0;
            entry_count_ff[i] <= '0;
            entry_wflag_ff[i] <= 1'b0;
         end
      end else if (cmd.commit && !found) begin
         next_slot_ff <= next_slot_in;
         if (req_ok_ff) begin
            entry_addr_ff[next_slot_ff]  <= req_addr_ff;
            entry_count_ff[next_slot_ff] <= req_count_ff;
            entry_wflag_ff[next_slot_ff] <= !req_read_ff;
         end else begin
            entry_addr_ff[next_slot_ff]  <= '0;
            entry_count_ff[next_slot_ff] <= '0;
            entry_wflag_ff[next_slot_ff] <= 1'b0;
         end
      end
   end

   // result beat: code[2:0] hit[3] wr_req[4] wr_cmd[12:5] failed[13]
   always_comb begin
      res_code   = '0;
      res_wr_cmd = '0;
      if (found) begin
         res_code = CODE_W'(first_idx);
      end else begin
         res_wr_cmd = WRITE_CMD_BASE + WR_CMD_W'(next_slot_ff);
         if (req_ok_ff) res_code = CODE_W'(next_slot_ff);
      end
      rsp_data_in = {2'b00, !found && !req_ok_ff, res_wr_cmd, !found, found, res_code};
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

[hw/rtl/cmt_checker.sv]
// ----------------------------------------------------------------------------
// cmt_checker
// Port-level checks of the mapping table result beats, bound to the top.
// ----------------------------------------------------------------------------
module cmt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cmt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import cmt_pkg::*;

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // a hit never asks for a device write
   a_hit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[13:4] == 10'd0)
      else $error("hit beat carries write request fields");

   // a miss always asks for a write in the 0x80 command range
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[4] && rsp_tdata[12:11] == 2'b10)
      else $error("miss beat without a proper write command");

   // failed write returns code zero, good write returns the written slot
   a_miss_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |->
         (rsp_tdata[13] && rsp_tdata[2:0] == 3'd0) ||
         (!rsp_tdata[13] && rsp_tdata[2:0] == rsp_tdata[7:5]))
      else $error("miss beat code does not match its slot");

endmodule

bind command_code_mapping_table cmt_checker u_cmt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the command code mapping table. A short directed
// table covers cleared slots, hits, misses, failed device writes and the
// round-robin wrap. A long random part follows, mostly drawn from small
// address and count pools so that the table hits often. Every result beat is
// compared with a predicted mapping, and both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import cmt_pkg::*;

   localparam int unsigned TABLE_ENTRIES = 8;
   localparam int unsigned N_DIRECTED    = 20;
   localparam int unsigned N_RANDOM      = 1250;
   localparam int unsigned STALL_LIMIT   = 2000;

   localparam logic [ADDR_W-1:0]  ADDR_POOL [6] =
      '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h00FF, 16'h7FFE};
   localparam logic [COUNT_W-1:0] COUNT_POOL [4] = '{8'h00, 8'h01, 8'h80, 8'hFF};

   typedef struct packed {
      logic [ADDR_W-1:0]  register_address;
      logic [COUNT_W-1:0] byte_count;
      logic               is_read;
      logic               write_ok;
   } access_type;

   typedef struct packed {
      logic [CODE_W-1:0]   command_code;
      logic                hit;
      logic                write_request;
      logic [WR_CMD_W-1:0] write_command;
      logic                failed;
   } mapping_type;

   typedef struct packed {
      access_type  access;
      logic        typed;
      mapping_type mapping;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predicted table contents
   logic [ADDR_W-1:0]  slot_address  [TABLE_ENTRIES];
   logic [COUNT_W-1:0] slot_count    [TABLE_ENTRIES];
   logic               slot_is_write [TABLE_ENTRIES];
   logic [CODE_W-1:0]  rr_slot;

   directed_row_type directed [N_DIRECTED];
   mapping_type      pending_mappings [$];
   int unsigned      n_accepted = 0;
   int unsigned      n_results  = 0;
   int unsigned      n_errors   = 0;
   int unsigned      quiet_cycles = 0;

   command_code_mapping_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic mapping_type map_access(access_type a);
      mapping_type       m;
      logic              found;
      logic [CODE_W-1:0] s;
      m = '0;
      found = 1'b0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (!found && slot_address[k] == a.register_address &&
             (a.is_read ? slot_count[k] == a.byte_count : slot_is_write[k])) begin
            found = 1'b1;
            m.command_code = CODE_W'(k);
            m.hit = 1'b1;
         end
      end
      if (!found) begin
         s = rr_slot;
         rr_slot = CODE_W'((int'(s) + 1) % TABLE_ENTRIES);
         if (a.write_ok) begin
            slot_address[s]  = a.register_address;
            slot_count[s]    = a.byte_count;
            slot_is_write[s] = !a.is_read;
            m.command_code   = s;
         end else begin
            slot_address[s]  = '0;
            slot_count[s]    = '0;
            slot_is_write[s] = 1'b0;
            m.failed         = 1'b1;
         end
         m.write_request = 1'b1;
         m.write_command = WRITE_CMD_BASE + WR_CMD_W'(s);
      end
      return m;
   endfunction

   // mostly pooled values so that entries get hit again
   function automatic access_type random_access();
      access_type a;
      if ($urandom_range(99) < 70) begin
         a.register_address = ADDR_POOL[$urandom_range(5)];
         a.byte_count       = COUNT_POOL[$urandom_range(3)];
      end else begin
         a.register_address = ADDR_W'($urandom());
         a.byte_count       = COUNT_W'($urandom());
      end
      a.is_read  = 1'($urandom_range(1));
      a.write_ok = ($urandom_range(99) < 85);
      return a;
   endfunction

   task automatic report(string field, int unsigned expected, int unsigned actual);
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, expected, actual);
      n_errors++;
   endtask

   // request side
   initial begin
      access_type a;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         slot_address[k]  = '0;
         slot_count[k]    = '0;
         slot_is_write[k] = 1'b0;
      end
      rr_slot = '0;

      //            address    count  rd    ok    typed  code  hit   wreq  wcmd   fail
      directed[0]  = '{'{16'h0000, 8'h00, 1'b1, 1'b1}, 1'b1, '{3'd0, 1'b1, 1'b0, 8'h00, 1'b0}};
      directed[1]  = '{'{16'h0000, 8'h00, 1'b0, 1'b1}, 1'b1, '{3'd0, 1'b0, 1'b1, 8'h80, 1'b0}};
      directed[2]  = '{'{16'h0000, 8'h5A, 1'b0, 1'b0}, 1'b1, '{3'd0, 1'b1, 1'b0, 8'h00, 1'b0}};
      directed[3]  = '{'{16'hFFFF, 8'hFF, 1'b1, 1'b1}, 1'b1, '{3'd1, 1'b0, 1'b1, 8'h81, 1'b0}};
      directed[4]  = '{'{16'hFFFF, 8'hFF, 1'b1, 1'b1}, 1'b1, '{3'd1, 1'b1, 1'b0, 8'h00, 1'b0}};
      directed[5]  = '{'{16'hFFFF, 8'hFE, 1'b1, 1'b0}, 1'b1, '{3'd0, 1'b0, 1'b1, 8'h82, 1'b1}};
      directed[6]  = '{'{16'h0000, 8'h00, 1'b1, 1'b1}, 1'b0, '0};
      directed[7]  = '{'{16'hFFFF, 8'h03, 1'b0, 1'b1}, 1'b0, '0};
      directed[8]  = '{'{16'hFFFF, 8'hC8, 1'b0, 1'b1}, 1'b0, '0};
      directed[9]  = '{'{16'h1234, 8'h04, 1'b1, 1'b1}, 1'b0, '0};
      directed[10] = '{'{16'h8000, 8'h00, 1'b0, 1'b1}, 1'b0, '0};
      directed[11] = '{'{16'h00FF, 8'h80, 1'b1, 1'b1}, 1'b0, '0};
      directed[12] = '{'{16'hAAAA, 8'h55, 1'b0, 1'b0}, 1'b1, '{3'd0, 1'b0, 1'b1, 8'h87, 1'b1}};
      directed[13] = '{'{16'h5555, 8'h01, 1'b1, 1'b1}, 1'b0, '0};
      directed[14] = '{'{16'h0000, 8'h00, 1'b0, 1'b1}, 1'b0, '0};
      directed[15] = '{'{16'h1234, 8'h04, 1'b1, 1'b0}, 1'b0, '0};
      directed[16] = '{'{16'h1234, 8'h05, 1'b1, 1'b1}, 1'b0, '0};
      directed[17] = '{'{16'h1234, 8'h05, 1'b0, 1'b1}, 1'b0, '0};
      directed[18] = '{'{16'h1234, 8'h00, 1'b0, 1'b1}, 1'b0, '0};
      directed[19] = '{'{16'hFFFF, 8'h00, 1'b1, 1'b1}, 1'b0, '0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
         a = (i < N_DIRECTED) ? directed[i].access : random_access();
         // no idling on the sender for a long middle stretch
         while (!(i >= 400 && i < 650) && $urandom_range(99) < 34) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {7'b0, a.write_ok, a.byte_count, a.register_address};
         req_tuser  <= a.is_read;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;

      do @(negedge clock);
      while (n_accepted < N_DIRECTED + N_RANDOM || pending_mappings.size() != 0);
      repeat (8) @(negedge clock);
      if (n_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // beat monitor: predicts on request beats, checks result beats
   always @(posedge clock) begin
      access_type  a;
      mapping_type predicted;
      mapping_type expected;
      mapping_type actual;
      logic        moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            a.register_address = req_tdata[15:0];
            a.byte_count       = req_tdata[23:16];
            a.write_ok         = req_tdata[24];
            a.is_read          = req_tuser;
            predicted = map_access(a);
            if (n_accepted < N_DIRECTED && directed[n_accepted].typed)
               predicted = directed[n_accepted].mapping;
            pending_mappings.push_back(predicted);
            n_accepted++;
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            actual.command_code  = rsp_tdata[2:0];
            actual.hit           = rsp_tdata[3];
            actual.write_request = rsp_tdata[4];
            actual.write_command = rsp_tdata[12:5];
            actual.failed        = rsp_tdata[13];
            if (pending_mappings.size() == 0) begin
               $error("result beat 0x%0h with no request waiting", rsp_tdata);
               n_errors++;
            end else begin
               expected = pending_mappings.pop_front();
               if (actual.command_code != expected.command_code)
                  report("command_code", 32'(expected.command_code),
                         32'(actual.command_code));
               if (actual.hit != expected.hit)
                  report("hit", 32'(expected.hit), 32'(actual.hit));
               if (actual.write_request != expected.write_request)
                  report("table_write_request", 32'(expected.write_request),
                         32'(actual.write_request));
               if (actual.write_command != expected.write_command)
                  report("table_write_command", 32'(expected.write_command),
                         32'(actual.write_command));
               if (actual.failed != expected.failed)
                  report("failed", 32'(expected.failed), 32'(actual.failed));
            end
            n_results++;
            moved = 1'b1;
         end
         // receiver never stalls over the same stretch as the sender
         rsp_tready <= (n_results >= 400 && n_results < 650) || ($urandom_range(99) >= 34);
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule
